FILE: src/tbrl_pkg.sv
// Shared types and constants for the token bucket rate limiter.
// Holds the sequencer state type, action and register codes, and fixed widths.
// No dependencies.
`default_nettype none

package tbrl_pkg;

    // Fixed widths of the datapath.
    localparam int LEVEL_W = 39;
    localparam int WMS_W   = 22;
    localparam int AVAIL_W = 17;
    localparam int WAIT_W  = 22;
    localparam int CNT_W   = 32;
    localparam int MUL_A_W = 17;
    localparam int MUL_B_W = 22;
    localparam int DVD_W   = 23;
    localparam int DCNT_W  = 5;

    // Action codes carried on the input side band.
    localparam logic [1:0] ACT_ADVANCE = 2'd0;
    localparam logic [1:0] ACT_ACQUIRE = 2'd1;
    localparam logic [1:0] ACT_REFILL  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_REQ = 2'd0;
    localparam logic [1:0] REG_WINDOW  = 2'd1;
    localparam logic [1:0] REG_BURST   = 2'd2;

    // Milliseconds per second, and x/10 as (x * 52429) >> 19 for 16-bit x.
    localparam int MS_PER_S      = 1000;
    localparam int TENTH_RECIP   = 52429;
    localparam int TENTH_SHIFT   = 19;

    // Register values after reset.
    localparam int MAX_REQ_RST_I = 100;
    localparam int WINDOW_RST_I  = 60;
    localparam int BURST_RST_I   = 10;

    localparam logic [15:0]        MAX_REQ_RESET = 16'(MAX_REQ_RST_I);
    localparam logic [11:0]        WINDOW_RESET  = 12'(WINDOW_RST_I);
    localparam logic [15:0]        BURST_RESET   = 16'(BURST_RST_I);
    localparam logic [WMS_W-1:0]   WMS_RESET     = WMS_W'(WINDOW_RST_I * MS_PER_S);
    localparam logic [LEVEL_W-1:0] CAP_RESET     =
        LEVEL_W'((MAX_REQ_RST_I + BURST_RST_I) * WINDOW_RST_I * MS_PER_S);

    // Saturation values.
    localparam logic [WAIT_W-1:0] WAIT_MAX = '1;
    localparam logic [CNT_W-1:0]  CNT_MAX  = '1;

    // Divider step counts (loaded value is steps minus one).
    localparam logic [DCNT_W-1:0] AVAIL_STEPS_M1 = DCNT_W'(AVAIL_W - 1);
    localparam logic [DCNT_W-1:0] WAIT_STEPS_M1  = DCNT_W'(DVD_W - 1);

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CFG_WMS,
        ST_CFG_CAP,
        ST_REFILL_MUL,
        ST_REFILL_ADD,
        ST_NEED_MUL,
        ST_APPLY,
        ST_AVAIL_LOAD,
        ST_AVAIL_DIV,
        ST_WAIT_LOAD,
        ST_WAIT_DIV,
        ST_FINISH
    } state_t;

endpackage

`default_nettype wire

FILE: src/token_bucket_rate_limiter.sv
// Token bucket rate limiter with burst allowance, built around one shared
// multiplier and one shared bit-serial divider under a small sequencer.
// Depends on tbrl_pkg.
//
//  Channel   Ports                          Contents
//  input     s_tvalid s_tready s_tdata      elapsed_ms, count (tuser: action)
//  result    m_tvalid m_tready m_tdata      granted .. denied_count
//  config    cfg_wr_en cfg_wr_index data    rate, window length, burst
//
// From acceptance to the next possible acceptance an item passes four
// multiply/update steps, 17 divider steps for the whole-token count and 23
// for the wait, which dominate. Items that hold a whole token, or whose rate
// is zero, skip the second division. A register write rebuilds the window
// length, then the capacity. Reset is synchronous; the bucket starts full.
// The result register lets a new item in while the last result is unread.
`default_nettype none

module token_bucket_rate_limiter
    import tbrl_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // input channel
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [31:0]  s_tdata,   // elapsed_ms[15:0], count[31:16]
    input  wire logic [1:0]   s_tuser,   // action[1:0]
    // result channel
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [111:0]      m_tdata,   // granted[0], tokens[17:1],
                                         // wait_ms[39:18], limited[40],
                                         // total_granted[72:41],
                                         // denied_count[104:73], zeros above
    // configuration write port
    input  wire logic         cfg_wr_en,
    input  wire logic [1:0]   cfg_wr_index,
    input  wire logic [15:0]  cfg_wr_data
);

    state_t state_reg, state_next;

    // Configuration and derived values
    logic [15:0]          max_req_reg;
    logic [11:0]          window_reg;
    logic [15:0]          burst_reg;
    logic [15:0]          beff_reg;
    logic [WMS_W-1:0]     wms_reg;
    logic [LEVEL_W-1:0]   cap_reg;

    // Bucket and counters
    logic [LEVEL_W-1:0]   level_reg;
    logic [CNT_W-1:0]     gtot_reg;
    logic [CNT_W-1:0]     dtot_reg;

    // Item being worked on
    logic [1:0]           action_reg;
    logic [15:0]          elapsed_reg;
    logic [15:0]          count_reg;
    logic [LEVEL_W-1:0]   prod_reg;
    logic                 granted_reg;
    logic [AVAIL_W-1:0]   avail_reg;
    logic [WAIT_W-1:0]    wait_reg;

    // Divider
    logic [WMS_W-1:0]     div_rem_reg;
    logic [DVD_W-1:0]     div_dvd_reg;
    logic [DVD_W-1:0]     div_quo_reg;
    logic [WMS_W-1:0]     div_den_reg;
    logic [DCNT_W-1:0]    div_cnt_reg;

    // Result register
    logic                 m_tvalid_reg;
    logic [111:0]         m_tdata_reg;

    // Combinational helpers
    logic                 cfg_hit;
    logic [11:0]          window_eff;
    logic [31:0]          tenth_prod;
    logic [15:0]          beff_new;
    logic [MUL_A_W-1:0]   mul_a;
    logic [MUL_B_W-1:0]   mul_b;
    logic [LEVEL_W-1:0]   mul_p;
    logic [LEVEL_W:0]     refill_sum;
    logic                 need_ok;
    logic [CNT_W:0]       gtot_sum;
    logic                 limited;
    logic [WMS_W-1:0]     short_by;
    logic                 wait_div;
    logic [DVD_W-1:0]     div_trial;
    logic                 div_ge;
    logic [WMS_W-1:0]     div_rem_new;
    logic [DVD_W-1:0]     div_quo_new;
    logic                 div_last;
    logic                 out_free;

    assign cfg_hit = cfg_wr_en && (cfg_wr_index == REG_MAX_REQ ||
                                   cfg_wr_index == REG_WINDOW ||
                                   cfg_wr_index == REG_BURST);

    // A zero window counts as one second; zero burst means a tenth of the rate.
    assign window_eff = (window_reg == 12'd0) ? 12'd1 : window_reg;
    assign tenth_prod = {16'd0, max_req_reg} * 32'(TENTH_RECIP);
    assign beff_new   = (burst_reg == 16'd0)
                      ? 16'(tenth_prod[31:TENTH_SHIFT]) : burst_reg;

    // Shared multiplier
    assign mul_p = {{(LEVEL_W-MUL_A_W){1'b0}}, mul_a} * {{(LEVEL_W-MUL_B_W){1'b0}}, mul_b};

    // Refill, capped at capacity
    assign refill_sum = {1'b0, level_reg} + {1'b0, prod_reg};

    // Acquire check and saturating grant sum
    assign need_ok  = level_reg >= prod_reg;
    assign gtot_sum = {1'b0, gtot_reg} + {{(CNT_W-15){1'b0}}, count_reg};

    // Fewer than one whole token held
    assign limited  = level_reg < {{(LEVEL_W-WMS_W){1'b0}}, wms_reg};
    assign short_by = wms_reg - level_reg[WMS_W-1:0];
    assign wait_div = limited && (max_req_reg != 16'd0);

    // One restoring division step
    assign div_trial   = {div_rem_reg, div_dvd_reg[DVD_W-1]};
    assign div_ge      = div_trial >= {1'b0, div_den_reg};
    assign div_rem_new = div_ge ? WMS_W'(div_trial - {1'b0, div_den_reg})
                                : div_trial[WMS_W-1:0];
    assign div_quo_new = {div_quo_reg[DVD_W-2:0], div_ge};
    assign div_last    = (div_cnt_reg == '0);

    assign out_free = !m_tvalid_reg || m_tready;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_tvalid) state_next = ST_REFILL_MUL;
            ST_CFG_WMS:    state_next = ST_CFG_CAP;
            ST_CFG_CAP:    state_next = ST_IDLE;
            ST_REFILL_MUL: state_next = ST_REFILL_ADD;
            ST_REFILL_ADD: state_next = ST_NEED_MUL;
            ST_NEED_MUL:   state_next = ST_APPLY;
            ST_APPLY:      state_next = ST_AVAIL_LOAD;
            ST_AVAIL_LOAD: state_next = ST_AVAIL_DIV;
            ST_AVAIL_DIV:  if (div_last) state_next = ST_WAIT_LOAD;
            ST_WAIT_LOAD:  state_next = wait_div ? ST_WAIT_DIV : ST_FINISH;
            ST_WAIT_DIV:   if (div_last) state_next = ST_FINISH;
            ST_FINISH:     if (out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
        // A register write rebuilds the derived values and refills the bucket.
        if (cfg_hit) begin
            state_next = ST_CFG_WMS;
        end
    end

    // Sequencer outputs: handshake and multiplier operands
    always_comb begin
        s_tready = 1'b0;
        mul_a    = '0;
        mul_b    = '0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_CFG_WMS: begin
                mul_a = MUL_A_W'(window_eff);
                mul_b = MUL_B_W'(MS_PER_S);
            end
            ST_CFG_CAP: begin
                mul_a = MUL_A_W'(max_req_reg) + MUL_A_W'(beff_reg);
                mul_b = wms_reg;
            end
            ST_REFILL_MUL: begin
                mul_a = MUL_A_W'(max_req_reg);
                mul_b = MUL_B_W'(elapsed_reg);
            end
            ST_NEED_MUL: begin
                mul_a = MUL_A_W'(count_reg);
                mul_b = wms_reg;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Configuration, bucket and counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_req_reg <= MAX_REQ_RESET;
            window_reg  <= WINDOW_RESET;
            burst_reg   <= BURST_RESET;
            beff_reg    <= BURST_RESET;
            wms_reg     <= WMS_RESET;
            cap_reg     <= CAP_RESET;
            level_reg   <= CAP_RESET;
            gtot_reg    <= '0;
            dtot_reg    <= '0;
        end else begin
            // Register writes
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    REG_MAX_REQ: max_req_reg <= cfg_wr_data;
                    REG_WINDOW:  window_reg  <= cfg_wr_data[11:0];
                    REG_BURST:   burst_reg   <= cfg_wr_data;
                    default:     ;
                endcase
            end
            case (state_reg)
                ST_CFG_WMS: begin
                    wms_reg  <= mul_p[WMS_W-1:0];
                    beff_reg <= beff_new;
                end
                ST_CFG_CAP: begin
                    cap_reg   <= mul_p;
                    level_reg <= mul_p;
                end
                ST_REFILL_ADD: begin
                    if (refill_sum > {1'b0, cap_reg}) begin
                        level_reg <= cap_reg;
                    end else begin
                        level_reg <= refill_sum[LEVEL_W-1:0];
                    end
                end
                ST_APPLY: begin
                    if (action_reg == ACT_ACQUIRE) begin
                        if (need_ok) begin
                            level_reg <= level_reg - prod_reg;
                            gtot_reg  <= gtot_sum[CNT_W] ? CNT_MAX : gtot_sum[CNT_W-1:0];
                        end else if (dtot_reg != CNT_MAX) begin
                            dtot_reg <= dtot_reg + CNT_W'(1);
                        end
                    end else if (action_reg == ACT_REFILL) begin
                        level_reg <= cap_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // Item datapath and divider
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                action_reg  <= s_tuser;
                elapsed_reg <= s_tdata[15:0];
                count_reg   <= s_tdata[31:16];
            end
            ST_REFILL_MUL, ST_NEED_MUL: begin
                prod_reg <= mul_p;
            end
            ST_APPLY: begin
                granted_reg <= (action_reg == ACT_ACQUIRE) && need_ok;
            end
            ST_AVAIL_LOAD: begin
                // The top bits are known to be below the window length.
                div_rem_reg <= level_reg[LEVEL_W-1:AVAIL_W];
                div_dvd_reg <= {level_reg[AVAIL_W-1:0], {(DVD_W-AVAIL_W){1'b0}}};
                div_quo_reg <= '0;
                div_den_reg <= wms_reg;
                div_cnt_reg <= AVAIL_STEPS_M1;
            end
            ST_AVAIL_DIV, ST_WAIT_DIV: begin
                div_rem_reg <= div_rem_new;
                div_dvd_reg <= {div_dvd_reg[DVD_W-2:0], 1'b0};
                div_quo_reg <= div_quo_new;
                div_cnt_reg <= div_cnt_reg - DCNT_W'(1);
                if (div_last && state_reg == ST_AVAIL_DIV) begin
                    avail_reg <= div_quo_new[AVAIL_W-1:0];
                end
                if (div_last && state_reg == ST_WAIT_DIV) begin
                    wait_reg <= div_quo_new[WAIT_W-1:0];
                end
            end
            ST_WAIT_LOAD: begin
                // Rounded-up wait: (short_by + rate - 1) / rate.
                div_rem_reg <= '0;
                div_dvd_reg <= DVD_W'(short_by) + DVD_W'(max_req_reg) - DVD_W'(1);
                div_quo_reg <= '0;
                div_den_reg <= WMS_W'(max_req_reg);
                div_cnt_reg <= WAIT_STEPS_M1;
                wait_reg    <= limited ? WAIT_MAX : '0;
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_tdata_reg <= {7'b0, dtot_reg, gtot_reg, limited,
                                    wait_reg, avail_reg, granted_reg};
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

FILE: src/tbrl_checker.sv
// Port-level checks for the token bucket rate limiter, bound to the top level.
// Sees only the top level's ports. Depends on token_bucket_rate_limiter.
`default_nettype none

module tbrl_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata
);

    // A waiting result stays offered.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A waiting result does not change.
    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while busy");

    // The limited flag matches an empty whole-token count.
    a_limited: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[40] == (m_tdata[17:1] == 17'd0)))
        else $error("limited flag disagrees with available tokens");

    // No wait is reported while a whole token is held.
    a_no_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[40] |-> (m_tdata[39:18] == 22'd0))
        else $error("wait reported while not limited");

endmodule

bind token_bucket_rate_limiter tbrl_checker u_tbrl_checker (.*);

`default_nettype wire
